// File: src/itrs_pkg.sv
// itrs_pkg: shared constants and helpers for the integer to radix string block.
// Used by itrs_div and int_to_radix_string. No dependencies.
`timescale 1ns / 1ps

package itrs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

  // Map one digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d > DIGIT_MAX) begin
      digit_char = dx - 7'd10 + CHAR_A;
    end else begin
      digit_char = dx + CHAR_ZERO;
    end
  endfunction

  // Clamp a raw radix register value into the usable range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      clamp_radix = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      clamp_radix = RADIX_MAX;
    end else begin
      clamp_radix = r;
    end
  endfunction

endpackage

// File: src/itrs_ram.sv
// itrs_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module itrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/itrs_div.sv
// itrs_div: restoring divider, one quotient bit per cycle, small divisor.
// Depends on itrs_pkg.
`timescale 1ns / 1ps

module itrs_div
  import itrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0]   cnt;
  logic [RADIX_W-1:0] dvsr;
  logic [RADIX_W:0]   trial;
  logic               fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {remainder, quotient[VALUE_WIDTH-1]};
  assign fits = trial >= {1'b0, dvsr};

  // Control: iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(VALUE_WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvsr <= divisor;
    end else if (cnt != '0) begin
      quotient <= {quotient[VALUE_WIDTH-2:0], fits};
      if (fits) begin
        remainder <= RADIX_W'(trial - {1'b0, dvsr});
      end else begin
        remainder <= trial[RADIX_W-1:0];
      end
    end
  end

endmodule

// File: src/int_to_radix_string.sv
// int_to_radix_string: top level, converts a signed integer to ASCII text in a set base.
// Depends on itrs_pkg, itrs_div and itrs_ram.
//
//   Channel  Direction  Payload                          Handshake
//   s_*      in         tdata: value                     s_tvalid/s_tready
//   m_*      out        tdata: char_code, tlast: is_last m_tvalid/m_tready
//   cfg_*    in         cfg_data: radix                  cfg_valid/cfg_ready
//
// Each digit is found by the shared bit-serial divider, then read back from the
// RAM and presented on m_*; a negative value first gets a minus sign, and a low
// m_tready stalls the output.
// Digits land in a small RAM least significant first and are read back in reverse.
// Reset (synchronous, rst high) sets radix to 10 and returns to idle.
// s_tready is high only when idle; a stalled m_tready holds the current character.
`timescale 1ns / 1ps

module int_to_radix_string
  import itrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int IN_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // Input words
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
  // Output characters
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [6:0] char_code, [7] zero
  output logic               m_tlast,   // is_last
  // Radix register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]             state;
  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     base;
  logic                   neg;
  logic [CNT_W-1:0]       ndig;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  logic [VALUE_WIDTH-1:0] in_value;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   in_take;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   more;
  logic [CNT_W-1:0]       ndig_dec;
  logic [CHAR_W-1:0]      rd_char;

  // Handshakes
  assign s_tready = (state == S_IDLE);
  assign in_take = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid = (state == S_SIGN) || (state == S_OUT);
  assign m_tdata = {1'b0, out_char};
  assign m_tlast = out_last;

  // Magnitude of the input, most negative value wraps to 2^(W-1) unsigned
  assign in_value = s_tdata[VALUE_WIDTH-1:0];
  assign in_mag = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  // Start a division on accept, and again while the quotient is nonzero
  assign more = (div_quo != '0);
  assign div_start = in_take || ((state == S_DIV) && div_done && more);
  assign div_dividend = in_take ? in_mag : div_quo;
  assign ndig_dec = ndig - 1'b1;

  itrs_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (in_take ? clamp_radix(radix) : base),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Digit store, written least significant first, read back in reverse
  itrs_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    ((state == S_DIV) && div_done),
    .waddr (ndig[AW-1:0]),
    .wdata (digit_char(div_rem)),
    .raddr (ndig_dec[AW-1:0]),
    .rdata (rd_char)
  );

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ndig <= '0;
      neg <= 1'b0;
      base <= RADIX_RESET;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            neg <= in_value[VALUE_WIDTH-1];
            base <= clamp_radix(radix);
            ndig <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ndig <= ndig + 1'b1;
            if (!more) begin
              state <= neg ? S_SIGN : S_READ;
            end
          end
        end
        S_SIGN: begin
          if (m_tready) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          ndig <= ndig_dec;
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= out_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output character register
  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done && !more && neg) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (state == S_LOAD) begin
      out_char <= rd_char;
      out_last <= (ndig == '0);
    end
  end

endmodule

// File: tb/sv/itrs_checker.sv
// itrs_checker: watches the value, character and radix channels of int_to_radix_string,
// predicts the character stream of each value and compares it word by word.
// Depends on itrs_pkg for widths and character constants.
`timescale 1ns / 1ps

module itrs_checker
  import itrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [31:0]        s_tdata,   // [31:0] value
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [7:0]         m_tdata,   // [6:0] char_code, [7] zero
  input  logic               m_tlast,   // is_last
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 chars_pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t         expected_chars[$];
  logic [RADIX_W-1:0] radix_copy;
  int                 mismatches = 0;
  int                 pending = 0;

  assign fail_count = mismatches;
  assign chars_pending = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Append the text form of one value: sign first, then digits most significant first
  function automatic void spell_in_radix(input logic [31:0] value,
                                         input logic [RADIX_W-1:0] r);
    logic [31:0]       base;
    logic [31:0]       mag;
    logic [31:0]       dig;
    logic [CHAR_W-1:0] lsd_first[$];
    base = (r < RADIX_MIN) ? 32'(RADIX_MIN) : (r > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(r);
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      dig = mag % base;
      if (dig > 32'(DIGIT_MAX)) begin
        lsd_first.push_back(CHAR_W'(dig - 32'd10 + 32'(CHAR_A)));
      end else begin
        lsd_first.push_back(CHAR_W'(dig + 32'(CHAR_ZERO)));
      end
      mag = mag / base;
    end while (mag != 0);
    if (value[31]) begin
      expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    for (int i = lsd_first.size() - 1; i >= 0; i--) begin
      expected_chars.push_back('{code: lsd_first[i], last: (i == 0)});
    end
  endfunction

  // Compare one output word against the oldest expected character
  task automatic check_char();
    text_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected character 0x%02h last=%0b", m_tdata, m_tlast));
    end else begin
      want = expected_chars.pop_front();
      if (m_tdata[CHAR_W-1:0] !== want.code) begin
        report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                  m_tdata[CHAR_W-1:0], want.code));
      end
      if (m_tdata[7] !== 1'b0) begin
        report_mismatch("tdata pad bit not zero");
      end
      if (m_tlast !== want.last) begin
        report_mismatch($sformatf("is_last %0b, expected %0b on char 0x%02h",
                                  m_tlast, want.last, want.code));
      end
    end
  endtask

  // Track the radix, retire output words first, then queue new predictions
  always @(posedge clk) begin
    if (rst) begin
      radix_copy = RADIX_RESET;
      expected_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_char();
      end
      if (cfg_valid && cfg_ready) begin
        radix_copy = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        spell_in_radix(s_tdata, radix_copy);
      end
    end
    pending = expected_chars.size();
  end

endmodule

// File: tb/sv/int_to_radix_string_tb.sv
// int_to_radix_string_tb: drives values and radix writes into int_to_radix_string,
// stalls the character stream, and reports the verdict of itrs_checker.
// Depends on itrs_pkg, int_to_radix_string and itrs_checker.
`timescale 1ns / 1ps

module int_to_radix_string_tb;
  import itrs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int HOLD_AFTER_CHARS = 600;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 34;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;   // [31:0] value
  logic               m_tvalid;
  logic               m_tready;
  logic [7:0]         m_tdata;   // [6:0] char_code, [7] zero
  logic               m_tlast;   // is_last
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data;

  int          fail_count;
  int          chars_pending;
  int          chars_seen = 0;
  int          idle_cycles = 0;
  logic [31:0] value_q[$];

  int_to_radix_string DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  itrs_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Write the radix once every expected character has come out
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    while (chars_pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer queued values in bursts with random gaps between them
  task automatic send_values();
    int burst;
    int gap;
    burst = $urandom_range(1, 8);
    while (value_q.size() != 0) begin
      s_tvalid = 1'b1;
      s_tdata = value_q.pop_front();
      do @(posedge clk); while (!s_tready);
      @(negedge clk);
      burst--;
      if (burst == 0) begin
        s_tvalid = 1'b0;
        s_tdata = $urandom();
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        repeat (gap) @(negedge clk);
        burst = $urandom_range(1, 10);
      end
    end
    s_tvalid = 1'b0;
  endtask

  // Mix short values, powers of the base and one below them, extremes and full-range words
  function automatic logic [31:0] pick_value(input logic [RADIX_W-1:0] r);
    logic [31:0] base;
    logic [31:0] p;
    logic [31:0] v;
    int          kind;
    int          k;
    base = (r < RADIX_MIN) ? 32'(RADIX_MIN) : (r > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(r);
    kind = $urandom_range(0, 7);
    case (kind)
      0: begin
        v = $urandom_range(0, base * base);
      end
      1: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p <= 32'h7FFF_FFFF / base) begin
          p = p * base;
          k--;
        end
        v = p - 32'($urandom_range(0, 1));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      3: begin
        v = $urandom_range(0, 32'hFFFF);
      end
      default: begin
        v = $urandom();
      end
    endcase
    if (kind < 4 && kind != 2 && $urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // Stimulus: directed values per radix, then random phases with random radix
  initial begin
    logic [RADIX_W-1:0] phase_radix;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Reset radix of ten: zero, one digit, carry to two digits, both extremes
    value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'h7FFF_FFFF, 32'h8000_0000};
    send_values();
    // Binary: longest strings, most negative value
    write_radix(6'd2);
    value_q = '{32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5};
    send_values();
    // Base 36: letter Z, rollover to two digits
    write_radix(6'd36);
    value_q = '{32'd35, 32'd36, -32'sd35, 32'd1295, 32'h8000_0000};
    send_values();
    write_radix(6'd16);
    value_q = '{32'hDEAD_BEEF, 32'd255};
    send_values();
    // Radix below two falls back to binary
    write_radix(6'd0);
    value_q = '{32'd6};
    send_values();
    write_radix(6'd1);
    value_q = '{-32'sd6};
    send_values();
    // Radix above 36 falls back to base 36
    write_radix(6'd37);
    value_q = '{32'd71};
    send_values();
    write_radix(6'd63);
    value_q = '{32'd35};
    send_values();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_radix = 6'd2;
        1: phase_radix = 6'd36;
        2: phase_radix = 6'd0;
        3: phase_radix = 6'd63;
        4: phase_radix = 6'd10;
        5: phase_radix = 6'd16;
        default: phase_radix = $urandom_range(0, 63);
      endcase
      write_radix(phase_radix);
      repeat (WORDS_PER_PHASE) value_q.push_back(pick_value(phase_radix));
      send_values();
    end

    while (chars_pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("int_to_radix_string test passed");
    end else begin
      $display("int_to_radix_string test failed");
    end
    $finish;
  end

  // Character sink: changing stall modes, plus one long hold-off to back up the input
  initial begin
    int mode;
    int mode_left;
    int tick;
    bit held;
    m_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && chars_seen >= HOLD_AFTER_CHARS) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = ($urandom_range(0, 3) != 0);
        2: m_tready = (tick % 3 == 0);
        default: m_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Count characters and end the run if no word moves for too long
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      chars_seen <= chars_seen + 1;
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("int_to_radix_string test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
